// ===== rtl/sha1_sh_pkg.sv =====
// Shared types, constants and round function for the SHA-1 stream hasher.
`default_nettype none

package sha1_sh_pkg;

  localparam int unsigned CmdDepth    = 4;
  localparam int unsigned DigestWords = 5;
  localparam int unsigned BlockWords  = 16;

  localparam logic [6:0] RoundLast  = 7'd79;
  localparam logic [7:0] PadByte    = 8'h80;
  localparam logic [5:0] LenBytePos = 6'd56;

  localparam logic [DigestWords-1:0][31:0] HInit = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  typedef enum logic {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
  } res_t;

  typedef struct packed {
    op_e         kind;
    logic [5:0]  pos;
    logic [7:0]  data;
    logic [63:0] bit_len;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } cmd_push_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  function automatic logic [31:0] round_fk(input logic [6:0] rnd, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    logic [31:0] k;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    return f + k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sha1_sh_front.sv =====
// Front end: accepts items, counts message bytes and builds commands.
`default_nettype none

module sha1_sh_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sha1_sh_pkg::item_t        item_i,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic                      q_full_i,
  output sha1_sh_pkg::cmd_push_t    q_push_o
);

  logic [63:0] byte_count_q, byte_count_d;
  logic        accept;
  logic        is_finish;

  assign accept    = push_i & ~q_full_i;
  assign full_o    = q_full_i;
  assign is_finish = (sha1_sh_pkg::op_e'(item_i.operation) == sha1_sh_pkg::OP_FINISH);

  always_comb begin
    q_push_o.push        = accept;
    q_push_o.cmd.kind    = sha1_sh_pkg::op_e'(item_i.operation);
    q_push_o.cmd.pos     = byte_count_q[5:0];
    q_push_o.cmd.data    = item_i.data_byte;
    q_push_o.cmd.bit_len = {byte_count_q[60:0], 3'b000};
    byte_count_d = byte_count_q;
    if (accept) begin
      if (is_finish) begin
        byte_count_d = '0;
      end else begin
        byte_count_d = byte_count_q + 64'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
    end else begin
      byte_count_q <= byte_count_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sha1_sh_cmdq.sv =====
// Command queue between the front end and the compression back end.
`default_nettype none

module sha1_sh_cmdq #(
  parameter int unsigned Depth = sha1_sh_pkg::CmdDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sha1_sh_pkg::cmd_push_t    push_i,
  output logic                      full_o,
  output sha1_sh_pkg::cmd_head_t    head_o,
  input  logic                      pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sha1_sh_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];
  assign do_push      = push_i.push & ~full_o;
  assign do_pop       = pop_i & head_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push |-> !full_o)
    else $error("command pushed into a full queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("command queue count out of range");

  a_cnt_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("command queue count did not advance on push");

endmodule

`default_nettype wire

// ===== rtl/sha1_sh_core.sv =====
// Back end: block buffer, padding, 80-round compression and digest output.
`default_nettype none

module sha1_sh_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sha1_sh_pkg::cmd_head_t    head_i,
  output logic                      pop_o,
  output sha1_sh_pkg::res_t         res_o,
  output logic                      empty_o,
  input  logic                      res_pop_i
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ROUND = 3'b010,
    ST_ADD   = 3'b100
  } core_state_e;

  localparam int unsigned NW = sha1_sh_pkg::DigestWords;
  localparam int unsigned BW = sha1_sh_pkg::BlockWords;

  core_state_e             state_q;
  logic [6:0]              rnd_q;
  logic [BW-1:0][31:0]     w_q, w_d;
  logic [NW-1:0][31:0]     h_q, h_sum, dig_q;
  logic [31:0]             a_q, b_q, c_q, d_q, e_q;
  logic [31:0]             t_sum, w_new;
  logic [63:0]             len_q;
  logic                    second_q, emit_q;
  logic [2:0]              out_left_q, out_idx_q;
  sha1_sh_pkg::cmd_t       cmd;
  logic                    take, is_absorb, pad_long, res_take;

  assign cmd       = head_i.cmd;
  assign is_absorb = (cmd.kind == sha1_sh_pkg::OP_ABSORB);
  assign pad_long  = (cmd.pos >= sha1_sh_pkg::LenBytePos);
  assign take      = (state_q == ST_IDLE) && head_i.valid && (is_absorb || out_left_q == '0);
  assign pop_o     = take;

  assign empty_o           = (out_left_q == '0);
  assign res_take          = res_pop_i & ~empty_o;
  assign res_o.digest_word = dig_q[0];
  assign res_o.word_index  = out_idx_q;
  assign res_o.last        = (out_idx_q == 3'(NW - 1));

  assign t_sum = {a_q[26:0], a_q[31:27]} + sha1_sh_pkg::round_fk(rnd_q, b_q, c_q, d_q)
               + e_q + w_q[0];
  assign w_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];

  assign h_sum[0] = h_q[0] + a_q;
  assign h_sum[1] = h_q[1] + b_q;
  assign h_sum[2] = h_q[2] + c_q;
  assign h_sum[3] = h_q[3] + d_q;
  assign h_sum[4] = h_q[4] + e_q;

  always_comb begin
    w_d = w_q;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          for (int j = 0; j < int'(BW); j++) begin
            for (int b = 0; b < 4; b++) begin
              if (6'(4 * j + b) == cmd.pos) begin
                w_d[j][31 - 8 * b -: 8] = is_absorb ? cmd.data : sha1_sh_pkg::PadByte;
              end else if (!is_absorb && 6'(4 * j + b) > cmd.pos) begin
                w_d[j][31 - 8 * b -: 8] = 8'h00;
              end
            end
          end
          if (!is_absorb && !pad_long) begin
            w_d[BW-2] = cmd.bit_len[63:32];
            w_d[BW-1] = cmd.bit_len[31:0];
          end
        end
      end
      ST_ROUND: begin
        for (int j = 0; j < int'(BW) - 1; j++) begin
          w_d[j] = w_q[j + 1];
        end
        w_d[BW-1] = {w_new[30:0], w_new[31]};
      end
      ST_ADD: begin
        if (second_q) begin
          w_d       = '0;
          w_d[BW-2] = len_q[63:32];
          w_d[BW-1] = len_q[31:0];
        end
      end
      default: begin
        w_d = w_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    if (take && !is_absorb) begin
      len_q <= cmd.bit_len;
    end
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          a_q <= h_q[0];
          b_q <= h_q[1];
          c_q <= h_q[2];
          d_q <= h_q[3];
          e_q <= h_q[4];
        end
      end
      ST_ROUND: begin
        a_q <= t_sum;
        b_q <= a_q;
        c_q <= {b_q[1:0], b_q[31:2]};
        d_q <= c_q;
        e_q <= d_q;
      end
      ST_ADD: begin
        a_q <= h_sum[0];
        b_q <= h_sum[1];
        c_q <= h_sum[2];
        d_q <= h_sum[3];
        e_q <= h_sum[4];
      end
      default: begin
        a_q <= a_q;
      end
    endcase
    if (state_q == ST_ADD && !second_q && emit_q) begin
      dig_q <= h_sum;
    end else if (res_take) begin
      dig_q <= {32'h0, dig_q[NW-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rnd_q      <= '0;
      h_q        <= sha1_sh_pkg::HInit;
      second_q   <= 1'b0;
      emit_q     <= 1'b0;
      out_left_q <= '0;
      out_idx_q  <= '0;
    end else begin
      if (res_take) begin
        out_left_q <= out_left_q - 3'd1;
        out_idx_q  <= out_idx_q + 3'd1;
      end
      case (state_q)
        ST_IDLE: begin
          if (take) begin
            rnd_q <= '0;
            if (is_absorb) begin
              second_q <= 1'b0;
              emit_q   <= 1'b0;
              if (&cmd.pos) begin
                state_q <= ST_ROUND;
              end
            end else begin
              second_q <= pad_long;
              emit_q   <= 1'b1;
              state_q  <= ST_ROUND;
            end
          end
        end
        ST_ROUND: begin
          rnd_q <= rnd_q + 7'd1;
          if (rnd_q == sha1_sh_pkg::RoundLast) begin
            state_q <= ST_ADD;
          end
        end
        ST_ADD: begin
          rnd_q <= '0;
          if (second_q) begin
            h_q      <= h_sum;
            second_q <= 1'b0;
            state_q  <= ST_ROUND;
          end else if (emit_q) begin
            h_q        <= sha1_sh_pkg::HInit;
            emit_q     <= 1'b0;
            out_left_q <= 3'(NW);
            out_idx_q  <= '0;
            state_q    <= ST_IDLE;
          end else begin
            h_q     <= h_sum;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_add_after_last_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD) |->
      ($past(state_q) == ST_ROUND && $past(rnd_q) == sha1_sh_pkg::RoundLast))
    else $error("feed-forward add without a full round sequence");

  a_out_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_left_q <= 3'(NW))
    else $error("digest word count out of range");

  a_out_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (({1'b0, out_left_q} + {1'b0, out_idx_q}) == 4'(NW)))
    else $error("digest index and remaining count disagree");

endmodule

`default_nettype wire

// ===== rtl/sha1_stream_hasher_top.sv =====
// Top level of the SHA-1 stream hasher: front end, command queue and back end.
//
//   channel   direction  ports                      accepted when
//   item      in         push, full, in_item_i      push & !full
//   digest    out        empty, pop, out_res_o      pop & !empty
//
// An absorb item only writes its byte into the block buffer; every 64th byte
// also runs the 80 compression rounds and a feed-forward add.
// A finish pads the block and runs the rounds and the add, twice when the length
// spills into a second block, then offers five digest words, one per pop.
// Reset clears the byte count and the queue and loads the initial chaining words.
// full rises while the command queue holds CmdDepth commands; a finish waits
// in the queue until the previous digest has been popped.
`default_nettype none

module sha1_stream_hasher_top #(
  parameter int unsigned CmdDepth = sha1_sh_pkg::CmdDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha1_sh_pkg::item_t  in_item_i,
  input  logic                push,
  output logic                full,
  output sha1_sh_pkg::res_t   out_res_o,
  output logic                empty,
  input  logic                pop
);

  sha1_sh_pkg::cmd_push_t  q_push;
  sha1_sh_pkg::cmd_head_t  q_head;
  logic                    q_full;
  logic                    q_pop;

  sha1_sh_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_item_i),
    .push_i   (push),
    .full_o   (full),
    .q_full_i (q_full),
    .q_push_o (q_push)
  );

  sha1_sh_cmdq #(
    .Depth (CmdDepth)
  ) u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .full_o (q_full),
    .head_o (q_head),
    .pop_i  (q_pop)
  );

  sha1_sh_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (q_head),
    .pop_o     (q_pop),
    .res_o     (out_res_o),
    .empty_o   (empty),
    .res_pop_i (pop)
  );

endmodule

`default_nettype wire

// ===== bench/sha1_digest_checker.sv =====
// Checker for the SHA-1 stream hasher: predicts digest words and compares them.
module sha1_digest_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha1_sh_pkg::item_t in_item_i,
  input  logic               push_i,
  input  logic               full_i,
  input  sha1_sh_pkg::res_t  out_res_i,
  input  logic               empty_i,
  input  logic               pop_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import sha1_sh_pkg::*;

  logic [31:0] chain_words [DigestWords];
  logic [7:0]  msg_block [64];
  logic [63:0] msg_bytes;
  res_t        digest_words_due [$];
  res_t        due_word;
  int          n_fail;

  function automatic logic [31:0] rol(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void fold_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain_words[0];
    b = chain_words[1];
    c = chain_words[2];
    d = chain_words[3];
    e = chain_words[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    chain_words[0] += a;
    chain_words[1] += b;
    chain_words[2] += c;
    chain_words[3] += d;
    chain_words[4] += e;
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < DigestWords; i++) chain_words[i] = HInit[i];
    msg_bytes = '0;
  endfunction

  function automatic void absorb_byte(input logic [7:0] data);
    int unsigned p;
    p = msg_bytes[5:0];
    msg_block[p] = data;
    msg_bytes++;
    if (p == 63) fold_block();
  endfunction

  function automatic void finish_message();
    int unsigned p;
    logic [63:0] bit_len;
    res_t        r;
    p = msg_bytes[5:0];
    msg_block[p] = PadByte;
    p++;
    // length no longer fits: close this block and pad a fresh one
    if (p > 56) begin
      while (p < 64) begin
        msg_block[p] = 8'h00;
        p++;
      end
      fold_block();
      p = 0;
    end
    while (p < 56) begin
      msg_block[p] = 8'h00;
      p++;
    end
    bit_len = msg_bytes << 3;
    for (int i = 0; i < 8; i++) msg_block[56 + i] = bit_len[63 - 8*i -: 8];
    fold_block();
    for (int i = 0; i < DigestWords; i++) begin
      r.digest_word = chain_words[i];
      r.word_index  = 3'(i);
      r.last        = (i == DigestWords - 1);
      digest_words_due.push_back(r);
    end
    restart_message();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_message();
      foreach (msg_block[i]) msg_block[i] = 8'h00;
      digest_words_due.delete();
      n_fail = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (digest_words_due.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected digest word: expected none, actual %h index %0d last %0b",
                   $time, out_res_i.digest_word, out_res_i.word_index, out_res_i.last);
        end else begin
          due_word = digest_words_due.pop_front();
          if (out_res_i.digest_word !== due_word.digest_word) begin
            n_fail++;
            $display("%0t: digest_word: expected %h, actual %h",
                     $time, due_word.digest_word, out_res_i.digest_word);
          end
          if (out_res_i.word_index !== due_word.word_index) begin
            n_fail++;
            $display("%0t: word_index: expected %0d, actual %0d",
                     $time, due_word.word_index, out_res_i.word_index);
          end
          if (out_res_i.last !== due_word.last) begin
            n_fail++;
            $display("%0t: last: expected %0b, actual %0b",
                     $time, due_word.last, out_res_i.last);
          end
        end
      end
      if (push_i && !full_i) begin
        if (in_item_i.operation == OP_FINISH) begin
          finish_message();
        end else begin
          absorb_byte(in_item_i.data_byte);
        end
      end
      fail_count_o <= n_fail;
      pending_o <= digest_words_due.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the SHA-1 stream hasher bench: clock, reset, message stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sha1_sh_pkg::*;

  typedef enum int {
    RX_EAGER,
    RX_HALF,
    RX_SPARSE,
    RX_STALL
  } rx_mode_e;

  logic     clk_i;
  logic     rst_ni = 1'b0;
  item_t    in_item = '0;
  logic     push = 1'b0;
  logic     full;
  res_t     out_res;
  logic     empty;
  logic     pop = 1'b0;
  int       fail_count;
  int       pending;
  int       items_sent = 0;
  int       burst_left = 0;
  rx_mode_e rx_mode = RX_EAGER;
  int       rx_left = 0;

  sha1_stream_hasher_top dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_item),
    .push      (push),
    .full      (full),
    .out_res_o (out_res),
    .empty     (empty),
    .pop       (pop)
  );

  sha1_digest_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_item_i    (in_item),
    .push_i       (push),
    .full_i       (full),
    .out_res_i    (out_res),
    .empty_i      (empty),
    .pop_i        (pop),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 80);
    end
    rx_left--;
    case (rx_mode)
      RX_EAGER: pop <= 1'b1;
      RX_HALF: pop <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: pop <= ($urandom_range(0, 3) == 0);
      default: pop <= ($urandom_range(0, 15) == 0);
    endcase
  end

  task automatic send_item(input op_e op, input logic [7:0] data);
    item_t it;
    int    gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    it.operation = op;
    it.data_byte = data;
    in_item <= it;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_item(OP_ABSORB, 8'($urandom_range(0, 255)));
    send_item(OP_FINISH, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned pick;
    int unsigned len;
    int unsigned edge_lens [8];
    edge_lens = '{54, 55, 56, 57, 62, 63, 64, 65};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_item(OP_FINISH, 8'hFF);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_ABSORB, 8'h61);
    send_item(OP_ABSORB, 8'h62);
    send_item(OP_ABSORB, 8'h63);
    send_item(OP_FINISH, 8'h5A);
    send_item(OP_ABSORB, 8'h00);
    send_item(OP_ABSORB, 8'hFF);
    send_item(OP_ABSORB, 8'h80);
    send_item(OP_FINISH, 8'hA5);

    while (items_sent < 320) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        len = $urandom_range(0, 12);
      end else if (pick < 8) begin
        len = edge_lens[$urandom_range(0, 7)];
      end else if (pick == 8) begin
        len = $urandom_range(100, 130);
      end else begin
        len = 0;
      end
      send_message(len);
    end

    push <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("sha1_stream_hasher_top: match");
    end else begin
      $display("sha1_stream_hasher_top: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("sha1_stream_hasher_top: mismatch");
    $finish;
  end

endmodule
